// ===== src/rrts_pkg.sv =====
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

   localparam int ID_W    = 4;
   localparam int KIND_W  = 4;
   localparam int DATA_W  = 64;
   localparam int RKIND_W = 2;
   localparam int QUANT_W = 8;
   localparam int ST_W    = 3;
   localparam int SLICE_W = 8;

   // Result buffer holds every word of one event.
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = 5;

   // Event kinds.
   localparam logic [KIND_W-1:0] EV_CREATE = 4'd0;
   localparam logic [KIND_W-1:0] EV_START  = 4'd1;
   localparam logic [KIND_W-1:0] EV_TICK   = 4'd2;
   localparam logic [KIND_W-1:0] EV_YIELD  = 4'd3;
   localparam logic [KIND_W-1:0] EV_EXIT   = 4'd4;
   localparam logic [KIND_W-1:0] EV_WAIT   = 4'd5;
   localparam logic [KIND_W-1:0] EV_BLOCK  = 4'd6;
   localparam logic [KIND_W-1:0] EV_WAKE   = 4'd7;
   localparam logic [KIND_W-1:0] EV_TERM   = 4'd8;
   localparam logic [KIND_W-1:0] EV_REAP   = 4'd9;

   // Result kinds.
   localparam logic [RKIND_W-1:0] RK_DONE    = 2'd0;
   localparam logic [RKIND_W-1:0] RK_WAKE    = 2'd1;
   localparam logic [RKIND_W-1:0] RK_TIMEOUT = 2'd2;
   localparam logic [RKIND_W-1:0] RK_RELEASE = 2'd3;

   // Slot states.
   localparam logic [ST_W-1:0] SS_UNUSED  = 3'd0;
   localparam logic [ST_W-1:0] SS_READY   = 3'd1;
   localparam logic [ST_W-1:0] SS_RUNNING = 3'd2;
   localparam logic [ST_W-1:0] SS_BLOCKED = 3'd3;
   localparam logic [ST_W-1:0] SS_EXITED  = 3'd4;

   localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd4;
   localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;

   // One classified event word from the front to the back.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   tid;
      logic [ID_W-1:0]   pin;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] detail;
      logic [DATA_W-1:0] delay;
      logic              tid_lt;
      logic              tid_nz;
      logic              pin_lt;
   } event_type;

   // One buffered result word.
   typedef struct packed {
      logic [RKIND_W-1:0] rkind;
      logic [ID_W-1:0]    target;
      logic [DATA_W-1:0]  value_a;
      logic [DATA_W-1:0]  value_b;
      logic               ok;
   } result_type;

endpackage

// ===== src/rrts_front.sv =====
// Front end: accepts event words, classifies them and queues them for the back end.
module rrts_front #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rrts_pkg::KIND_W-1:0]    req_kind,
   input  logic [rrts_pkg::ID_W-1:0]      req_task_id,
   input  logic [rrts_pkg::ID_W-1:0]      req_parent_id,
   input  logic [rrts_pkg::DATA_W-1:0]    req_value,
   input  logic [rrts_pkg::DATA_W-1:0]    req_detail,
   input  logic [rrts_pkg::DATA_W-1:0]    req_delay,
   output logic                           ev_valid,
   output rrts_pkg::event_type            ev_word,
   input  logic                           ev_pop
);

   localparam int SW = $clog2(TASK_SLOTS);
   localparam int IW = (SW + 1 > rrts_pkg::ID_W) ? SW + 1 : rrts_pkg::ID_W;

   rrts_pkg::event_type q_ff [2];
   logic                wr_ff, wr_in;
   logic                rd_ff, rd_in;
   logic [1:0]          cnt_ff, cnt_in;
   rrts_pkg::event_type cls;
   logic                push;

   // Classify the incoming word: slot number range checks and a nonzero task id check.
   always_comb begin
      cls.kind   = req_kind;
      cls.tid    = req_task_id;
      cls.pin    = req_parent_id;
      cls.value  = req_value;
      cls.detail = req_detail;
      cls.delay  = req_delay;
      cls.tid_lt = IW'(req_task_id) < IW'(TASK_SLOTS);
      cls.tid_nz = req_task_id != '0;
      cls.pin_lt = IW'(req_parent_id) < IW'(TASK_SLOTS);
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign ev_valid  = cnt_ff != 2'd0;
   assign ev_word   = q_ff[rd_ff];

   // Two-word queue pointers.
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = ev_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + (push ? 2'd1 : 2'd0) - (ev_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

// ===== src/rrts_back.sv =====
// Back end: slot table, event sequencer, result buffer and result register.
module rrts_back #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rrts_pkg::QUANT_W-1:0]    quantum,
   input  logic                            ev_valid,
   input  rrts_pkg::event_type             ev_word,
   output logic                            ev_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrts_pkg::RKIND_W-1:0]    rsp_result_kind,
   output logic [rrts_pkg::ID_W-1:0]       rsp_target_task,
   output logic [rrts_pkg::DATA_W-1:0]     rsp_value_a,
   output logic [rrts_pkg::DATA_W-1:0]     rsp_value_b,
   output logic                            rsp_ok,
   output logic [rrts_pkg::ID_W-1:0]       rsp_running_task,
   output logic                            rsp_users_active,
   output logic                            rsp_last
);

   localparam int SW = $clog2(TASK_SLOTS);
   localparam int IW = (SW + 1 > rrts_pkg::ID_W) ? SW + 1 : rrts_pkg::ID_W;
   localparam int DW = rrts_pkg::DATA_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);
   localparam logic [SW-1:0] STEPS_END = SW'(TASK_SLOTS - 2);

   // Sequencer states.
   localparam logic [3:0] B_IDLE    = 4'd0;
   localparam logic [3:0] B_DECODE  = 4'd1;
   localparam logic [3:0] B_CREATE  = 4'd2;
   localparam logic [3:0] B_RS0     = 4'd3;
   localparam logic [3:0] B_SCAN    = 4'd4;
   localparam logic [3:0] B_RESOLVE = 4'd5;
   localparam logic [3:0] B_TICK_RD = 4'd6;
   localparam logic [3:0] B_TICK_EV = 4'd7;
   localparam logic [3:0] B_SLICE   = 4'd8;
   localparam logic [3:0] B_REAP    = 4'd9;
   localparam logic [3:0] B_WPAR    = 4'd10;
   localparam logic [3:0] B_REL     = 4'd11;
   localparam logic [3:0] B_DONE    = 4'd12;
   localparam logic [3:0] B_DRAIN   = 4'd13;

   // What a ready-slot scan is for.
   localparam logic [1:0] P_START   = 2'd0;
   localparam logic [1:0] P_RESCHED = 2'd1;
   localparam logic [1:0] P_EXIT    = 2'd2;

   function automatic logic [SW-1:0] to_slot(input logic [rrts_pkg::ID_W-1:0] id);
      logic [IW-1:0] w;
      w = IW'(id);
      return w[SW-1:0];
   endfunction

   function automatic logic [rrts_pkg::ID_W-1:0] to_id(input logic [SW-1:0] s);
      logic [IW-1:0] w;
      w = IW'(s);
      return w[rrts_pkg::ID_W-1:0];
   endfunction

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      return (s == LAST_SLOT) ? SW'(1) : s + SW'(1);
   endfunction

   // Slot table, narrow fields in flops.
   logic [rrts_pkg::ST_W-1:0]    state_ff  [TASK_SLOTS];
   logic [rrts_pkg::ST_W-1:0]    state_in  [TASK_SLOTS];
   logic [rrts_pkg::ID_W-1:0]    parent_ff [TASK_SLOTS];
   logic [rrts_pkg::ID_W-1:0]    parent_in [TASK_SLOTS];
   logic [rrts_pkg::ID_W-1:0]    await_ff  [TASK_SLOTS];
   logic [rrts_pkg::ID_W-1:0]    await_in  [TASK_SLOTS];
   logic                         timed_ff  [TASK_SLOTS];
   logic                         timed_in  [TASK_SLOTS];
   logic [rrts_pkg::SLICE_W-1:0] slice_ff  [TASK_SLOTS];
   logic [rrts_pkg::SLICE_W-1:0] slice_in  [TASK_SLOTS];

   // Wide per-slot fields in memories.
   logic [DW-1:0] exit_mem [TASK_SLOTS];
   logic [DW-1:0] wake_mem [TASK_SLOTS];
   logic [DW-1:0] tout_mem [TASK_SLOTS];
   logic [DW-1:0] exit_rd_ff, wake_rd_ff, tout_rd_ff;
   logic          exit_we, timer_we;
   logic [SW-1:0] exit_wa, timer_wa;
   logic [DW-1:0] timer_wake;

   // Scheduler registers.
   logic [SW-1:0] cur_ff, cur_in;
   logic          users_ff, users_in;
   logic [DW-1:0] tick_ff, tick_in;

   // Sequencer registers.
   logic [3:0]          st_ff, st_in;
   rrts_pkg::event_type ev_ff, ev_in;
   logic [SW-1:0]       sc_ff, sc_in;
   logic [SW-1:0]       steps_ff, steps_in;
   logic [SW-1:0]       found_ff, found_in;
   logic                hit_ff, hit_in;
   logic [1:0]          purp_ff, purp_in;
   logic [SW-1:0]       ch_ff, ch_in;
   logic [rrts_pkg::ID_W-1:0] tgt_ff, tgt_in;
   logic [DW-1:0]       va_ff, va_in;
   logic [DW-1:0]       vb_ff, vb_in;
   logic                ok_ff, ok_in;

   // Result buffer and output register.
   rrts_pkg::result_type buf_mem [rrts_pkg::MAX_RESULTS];
   logic [rrts_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [rrts_pkg::CNT_W-1:0] rd_ff, rd_in;
   logic                       emit_we;
   rrts_pkg::result_type       emit_word;
   rrts_pkg::result_type       rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::ID_W-1:0]  rsp_run_ff, rsp_run_in;
   logic                       rsp_users_ff, rsp_users_in;

   logic [SW-1:0]                tid_s;
   logic [SW-1:0]                par_s;
   logic [rrts_pkg::ID_W-1:0]    par_id;
   logic                         user_ctx;
   logic                         load_ok;
   logic [rrts_pkg::SLICE_W-1:0] nslice;
   logic [rrts_pkg::CNT_W-1:0]   rd_slot;

   assign tid_s    = to_slot(ev_ff.tid);
   assign par_id   = parent_ff[ch_ff];
   assign par_s    = to_slot(par_id);
   assign user_ctx = users_ff && (cur_ff != '0);
   assign load_ok  = !rsp_valid_ff || !rsp_stall;
   assign rd_slot  = rd_ff;

   // Event sequencer.
   always_comb begin
      state_in  = state_ff;
      parent_in = parent_ff;
      await_in  = await_ff;
      timed_in  = timed_ff;
      slice_in  = slice_ff;
      cur_in    = cur_ff;
      users_in  = users_ff;
      tick_in   = tick_ff;
      st_in     = st_ff;
      ev_in     = ev_ff;
      sc_in     = sc_ff;
      steps_in  = steps_ff;
      found_in  = found_ff;
      hit_in    = hit_ff;
      purp_in   = purp_ff;
      ch_in     = ch_ff;
      tgt_in    = tgt_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      ok_in     = ok_ff;
      cnt_in    = cnt_ff;
      rd_in     = rd_ff;
      ev_pop    = 1'b0;
      exit_we   = 1'b0;
      exit_wa   = cur_ff;
      timer_we  = 1'b0;
      timer_wa  = cur_ff;
      timer_wake = tick_ff + ev_ff.delay;
      emit_we   = 1'b0;
      emit_word = '0;
      nslice    = slice_ff[cur_ff];
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_run_in   = rsp_run_ff;
      rsp_users_in = rsp_users_ff;

      unique case (st_ff)
         B_IDLE: begin
            if (ev_valid) begin
               ev_pop = 1'b1;
               ev_in  = ev_word;
               cnt_in = '0;
               tgt_in = '0;
               va_in  = '0;
               vb_in  = '0;
               ok_in  = 1'b0;
               st_in  = B_DECODE;
            end
         end

         B_DECODE: begin
            st_in = B_DONE;
            unique case (ev_ff.kind)
               rrts_pkg::EV_CREATE: begin
                  if (ev_ff.pin_lt) begin
                     sc_in = SW'(1);
                     st_in = B_CREATE;
                  end
               end
               rrts_pkg::EV_START: begin
                  if (!users_ff) begin
                     sc_in    = SW'(1);
                     steps_in = '0;
                     purp_in  = P_START;
                     st_in    = B_SCAN;
                  end
               end
               rrts_pkg::EV_TICK: begin
                  tick_in = tick_ff + DW'(1);
                  ok_in   = 1'b1;
                  sc_in   = SW'(1);
                  st_in   = B_TICK_RD;
               end
               rrts_pkg::EV_YIELD: begin
                  tgt_in = to_id(cur_ff);
                  if (user_ctx) begin
                     ok_in = 1'b1;
                     st_in = B_RS0;
                  end
               end
               rrts_pkg::EV_EXIT: begin
                  tgt_in = to_id(cur_ff);
                  if (user_ctx) begin
                     ok_in            = 1'b1;
                     exit_we          = 1'b1;
                     exit_wa          = cur_ff;
                     state_in[cur_ff] = rrts_pkg::SS_EXITED;
                     ch_in            = cur_ff;
                     st_in            = B_WPAR;
                  end
               end
               rrts_pkg::EV_WAIT: begin
                  tgt_in = ev_ff.tid;
                  if (ev_ff.tid_nz && ev_ff.tid_lt &&
                      IW'(parent_ff[tid_s]) == IW'(cur_ff) &&
                      state_ff[tid_s] == rrts_pkg::SS_EXITED) begin
                     st_in = B_REAP;
                  end else if (cur_ff == '0 || !ev_ff.tid_lt ||
                               IW'(parent_ff[tid_s]) != IW'(cur_ff) ||
                               state_ff[tid_s] == rrts_pkg::SS_UNUSED) begin
                     va_in = '1;
                  end else begin
                     state_in[cur_ff] = rrts_pkg::SS_BLOCKED;
                     await_in[cur_ff] = ev_ff.tid;
                     ok_in            = 1'b1;
                     st_in            = B_RS0;
                  end
               end
               rrts_pkg::EV_BLOCK: begin
                  tgt_in = to_id(cur_ff);
                  if (user_ctx) begin
                     state_in[cur_ff] = rrts_pkg::SS_BLOCKED;
                     if (ev_ff.delay != '0) begin
                        timer_we         = 1'b1;
                        timer_wa         = cur_ff;
                        timed_in[cur_ff] = 1'b1;
                     end else begin
                        timed_in[cur_ff] = 1'b0;
                     end
                     ok_in = 1'b1;
                     st_in = B_RS0;
                  end
               end
               rrts_pkg::EV_WAKE: begin
                  tgt_in = ev_ff.tid;
                  if (ev_ff.tid_nz && ev_ff.tid_lt &&
                      state_ff[tid_s] == rrts_pkg::SS_BLOCKED) begin
                     emit_we           = 1'b1;
                     emit_word.rkind   = rrts_pkg::RK_WAKE;
                     emit_word.target  = ev_ff.tid;
                     emit_word.value_a = ev_ff.value;
                     emit_word.value_b = ev_ff.detail;
                     emit_word.ok      = 1'b1;
                     timed_in[tid_s]   = 1'b0;
                     state_in[tid_s]   = rrts_pkg::SS_READY;
                     ok_in             = 1'b1;
                  end
               end
               rrts_pkg::EV_TERM: begin
                  tgt_in = ev_ff.tid;
                  if (ev_ff.tid_nz && ev_ff.tid_lt && tid_s != cur_ff &&
                      state_ff[tid_s] != rrts_pkg::SS_UNUSED &&
                      state_ff[tid_s] != rrts_pkg::SS_EXITED) begin
                     exit_we         = 1'b1;
                     exit_wa         = tid_s;
                     state_in[tid_s] = rrts_pkg::SS_EXITED;
                     ch_in           = tid_s;
                     ok_in           = 1'b1;
                     st_in           = B_WPAR;
                  end
               end
               rrts_pkg::EV_REAP: begin
                  tgt_in = ev_ff.tid;
                  if (ev_ff.tid_nz && ev_ff.tid_lt &&
                      parent_ff[tid_s] == ev_ff.pin &&
                      state_ff[tid_s] == rrts_pkg::SS_EXITED) begin
                     st_in = B_REAP;
                  end
               end
               default: begin
               end
            endcase
         end

         // First unused slot takes the new task.
         B_CREATE: begin
            if (state_ff[sc_ff] == rrts_pkg::SS_UNUSED) begin
               state_in[sc_ff]  = rrts_pkg::SS_READY;
               parent_in[sc_ff] = ev_ff.pin;
               await_in[sc_ff]  = '0;
               timed_in[sc_ff]  = 1'b0;
               slice_in[sc_ff]  = '0;
               tgt_in           = to_id(sc_ff);
               va_in            = DW'(sc_ff);
               ok_in            = 1'b1;
               st_in            = B_DONE;
            end else if (sc_ff == LAST_SLOT) begin
               st_in = B_DONE;
            end else begin
               sc_in = sc_ff + SW'(1);
            end
         end

         // Reschedule: demote the running task, then scan after it.
         B_RS0: begin
            if (state_ff[cur_ff] == rrts_pkg::SS_RUNNING) begin
               state_in[cur_ff] = rrts_pkg::SS_READY;
            end
            sc_in    = next_slot(cur_ff);
            steps_in = '0;
            purp_in  = P_RESCHED;
            st_in    = B_SCAN;
         end

         // Round-robin scan for a ready slot, one slot per cycle.
         B_SCAN: begin
            if (state_ff[sc_ff] == rrts_pkg::SS_READY) begin
               found_in = sc_ff;
               hit_in   = 1'b1;
               st_in    = B_RESOLVE;
            end else if (steps_ff == STEPS_END) begin
               hit_in = 1'b0;
               st_in  = B_RESOLVE;
            end else begin
               sc_in    = next_slot(sc_ff);
               steps_in = steps_ff + SW'(1);
            end
         end

         B_RESOLVE: begin
            st_in = B_DONE;
            if (hit_ff) begin
               if (purp_ff == P_START) begin
                  state_in[0] = rrts_pkg::SS_READY;
                  users_in    = 1'b1;
                  tgt_in      = to_id(found_ff);
                  ok_in       = 1'b1;
               end
               cur_in             = found_ff;
               state_in[found_ff] = rrts_pkg::SS_RUNNING;
               slice_in[found_ff] = '0;
            end else if (purp_ff == P_RESCHED &&
                         state_ff[cur_ff] == rrts_pkg::SS_READY) begin
               state_in[cur_ff] = rrts_pkg::SS_RUNNING;
            end else if (purp_ff != P_START) begin
               users_in    = 1'b0;
               cur_in      = '0;
               state_in[0] = rrts_pkg::SS_RUNNING;
            end
         end

         B_TICK_RD: begin
            st_in = B_TICK_EV;
         end

         // Timed waits that have expired become ready while the result buffer has room.
         B_TICK_EV: begin
            st_in = B_TICK_RD;
            if (state_ff[sc_ff] == rrts_pkg::SS_BLOCKED && timed_ff[sc_ff] &&
                tick_ff >= wake_rd_ff) begin
               if (cnt_ff >= rrts_pkg::CNT_W'(rrts_pkg::MAX_RESULTS - 1)) begin
                  st_in = B_SLICE;
               end else begin
                  emit_we           = 1'b1;
                  emit_word.rkind   = rrts_pkg::RK_TIMEOUT;
                  emit_word.target  = to_id(sc_ff);
                  emit_word.value_a = tout_rd_ff;
                  emit_word.value_b = '0;
                  emit_word.ok      = 1'b1;
                  timed_in[sc_ff]   = 1'b0;
                  state_in[sc_ff]   = rrts_pkg::SS_READY;
               end
            end
            if (sc_ff == LAST_SLOT) begin
               st_in = B_SLICE;
            end else begin
               sc_in = sc_ff + SW'(1);
            end
         end

         // Quantum accounting of the running user task.
         B_SLICE: begin
            st_in = B_DONE;
            if (user_ctx) begin
               nslice = (slice_ff[cur_ff] == rrts_pkg::SLICE_MAX) ?
                        rrts_pkg::SLICE_MAX : slice_ff[cur_ff] + 8'd1;
               slice_in[cur_ff] = nslice;
               if (nslice >= quantum) begin
                  st_in = B_RS0;
               end
            end
         end

         // Reap an exited child; the exit code is read back from memory.
         B_REAP: begin
            if (ev_ff.kind == rrts_pkg::EV_WAIT) begin
               va_in = DW'(ev_ff.tid);
               vb_in = exit_rd_ff;
            end else begin
               va_in = exit_rd_ff;
            end
            ok_in             = 1'b1;
            emit_we           = 1'b1;
            emit_word.rkind   = rrts_pkg::RK_RELEASE;
            emit_word.target  = ev_ff.tid;
            emit_word.value_a = exit_rd_ff;
            emit_word.value_b = '0;
            emit_word.ok      = 1'b1;
            state_in[tid_s]   = rrts_pkg::SS_UNUSED;
            parent_in[tid_s]  = '0;
            await_in[tid_s]   = '0;
            timed_in[tid_s]   = 1'b0;
            slice_in[tid_s]   = '0;
            st_in             = B_DONE;
         end

         // A blocked parent waiting on this child gets its exit status.
         B_WPAR: begin
            if (par_id != '0 && state_ff[par_s] == rrts_pkg::SS_BLOCKED &&
                (await_ff[par_s] == '0 || IW'(await_ff[par_s]) == IW'(ch_ff))) begin
               emit_we           = 1'b1;
               emit_word.rkind   = rrts_pkg::RK_WAKE;
               emit_word.target  = par_id;
               emit_word.value_a = DW'(ch_ff);
               emit_word.value_b = ev_ff.value;
               emit_word.ok      = 1'b1;
               state_in[par_s]   = rrts_pkg::SS_READY;
               timed_in[par_s]   = 1'b0;
               st_in             = B_REL;
            end else if (ev_ff.kind == rrts_pkg::EV_EXIT) begin
               sc_in    = next_slot(cur_ff);
               steps_in = '0;
               purp_in  = P_EXIT;
               st_in    = B_SCAN;
            end else begin
               st_in = B_DONE;
            end
         end

         B_REL: begin
            emit_we           = 1'b1;
            emit_word.rkind   = rrts_pkg::RK_RELEASE;
            emit_word.target  = to_id(ch_ff);
            emit_word.value_a = ev_ff.value;
            emit_word.value_b = '0;
            emit_word.ok      = 1'b1;
            state_in[ch_ff]   = rrts_pkg::SS_UNUSED;
            parent_in[ch_ff]  = '0;
            await_in[ch_ff]   = '0;
            timed_in[ch_ff]   = 1'b0;
            slice_in[ch_ff]   = '0;
            if (ev_ff.kind == rrts_pkg::EV_EXIT) begin
               sc_in    = next_slot(cur_ff);
               steps_in = '0;
               purp_in  = P_EXIT;
               st_in    = B_SCAN;
            end else begin
               st_in = B_DONE;
            end
         end

         B_DONE: begin
            emit_we           = 1'b1;
            emit_word.rkind   = rrts_pkg::RK_DONE;
            emit_word.target  = tgt_ff;
            emit_word.value_a = va_ff;
            emit_word.value_b = vb_ff;
            emit_word.ok      = ok_ff;
            rd_in             = '0;
            st_in             = B_DRAIN;
         end

         // Hand the buffered words to the result register.
         B_DRAIN: begin
            if (load_ok) begin
               rsp_in       = buf_mem[rd_slot[$clog2(rrts_pkg::MAX_RESULTS)-1:0]];
               rsp_valid_in = 1'b1;
               rsp_run_in   = to_id(cur_ff);
               rsp_users_in = users_ff;
               rd_in        = rd_ff + rrts_pkg::CNT_W'(1);
               if (buf_mem[rd_slot[$clog2(rrts_pkg::MAX_RESULTS)-1:0]].rkind ==
                   rrts_pkg::RK_DONE) begin
                  st_in = B_IDLE;
               end
            end
         end

         default: begin
            st_in = B_IDLE;
         end
      endcase

      if (emit_we) begin
         cnt_in = cnt_ff + rrts_pkg::CNT_W'(1);
      end
   end

   // Control and table registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            state_ff[i]  <= (i == 0) ? rrts_pkg::SS_RUNNING : rrts_pkg::SS_UNUSED;
            parent_ff[i] <= '0;
            await_ff[i]  <= '0;
            timed_ff[i]  <= 1'b0;
            slice_ff[i]  <= '0;
         end
         cur_ff       <= '0;
         users_ff     <= 1'b0;
         tick_ff      <= '0;
         st_ff        <= B_IDLE;
         cnt_ff       <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         parent_ff    <= parent_in;
         await_ff     <= await_in;
         timed_ff     <= timed_in;
         slice_ff     <= slice_in;
         cur_ff       <= cur_in;
         users_ff     <= users_in;
         tick_ff      <= tick_in;
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ev_ff        <= ev_in;
      sc_ff        <= sc_in;
      steps_ff     <= steps_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      purp_ff      <= purp_in;
      ch_ff        <= ch_in;
      tgt_ff       <= tgt_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      ok_ff        <= ok_in;
      rsp_ff       <= rsp_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_users_ff <= rsp_users_in;
   end

   // Exit code memory, read at the event's task slot.
   always_ff @(posedge clock) begin
      if (exit_we) begin
         exit_mem[exit_wa] <= ev_ff.value;
      end
      exit_rd_ff <= exit_mem[tid_s];
   end

   // Timer memories, read at the tick scan pointer.
   always_ff @(posedge clock) begin
      if (timer_we) begin
         wake_mem[timer_wa] <= timer_wake;
         tout_mem[timer_wa] <= ev_ff.value;
      end
      wake_rd_ff <= wake_mem[sc_ff];
      tout_rd_ff <= tout_mem[sc_ff];
   end

   // Result buffer.
   always_ff @(posedge clock) begin
      if (emit_we) begin
         buf_mem[cnt_ff[$clog2(rrts_pkg::MAX_RESULTS)-1:0]] <= emit_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_ff.rkind;
   assign rsp_target_task  = rsp_ff.target;
   assign rsp_value_a      = rsp_ff.value_a;
   assign rsp_value_b      = rsp_ff.value_b;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_running_task = rsp_run_ff;
   assign rsp_users_active = rsp_users_ff;
   assign rsp_last         = rsp_ff.rkind == rrts_pkg::RK_DONE;

endmodule

// ===== src/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler with a time quantum.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  kind, task_id, parent_id, value, detail, delay
//   rsp_     out        rsp_valid / rsp_stall  result_kind ... last, one word per result
//   csr_     in         csr_valid / csr_ready  quantum_ticks
//
// An event is decoded and then runs its scans: a ready-slot or free-slot scan, and for
// a tick a timer pass that visits each slot in a read state and then an evaluate state,
// since each slot's wake time comes from a registered memory read.
// Its result words leave one per cycle through the output register unless rsp_stall holds.
// Reset is synchronous; the slot table comes out of reset at once with no clearing pass.
// A two-word queue takes events while the back end works or rsp_stall holds it, until full.
module round_robin_task_scheduler #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rrts_pkg::KIND_W-1:0]    req_kind,
   input  logic [rrts_pkg::ID_W-1:0]      req_task_id,
   input  logic [rrts_pkg::ID_W-1:0]      req_parent_id,
   input  logic [rrts_pkg::DATA_W-1:0]    req_value,
   input  logic [rrts_pkg::DATA_W-1:0]    req_detail,
   input  logic [rrts_pkg::DATA_W-1:0]    req_delay,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rrts_pkg::RKIND_W-1:0]   rsp_result_kind,
   output logic [rrts_pkg::ID_W-1:0]      rsp_target_task,
   output logic [rrts_pkg::DATA_W-1:0]    rsp_value_a,
   output logic [rrts_pkg::DATA_W-1:0]    rsp_value_b,
   output logic                           rsp_ok,
   output logic [rrts_pkg::ID_W-1:0]      rsp_running_task,
   output logic                           rsp_users_active,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrts_pkg::QUANT_W-1:0]   csr_quantum_ticks
);

   logic [rrts_pkg::QUANT_W-1:0] quant_ff;
   logic                         ev_valid;
   rrts_pkg::event_type          ev_word;
   logic                         ev_pop;

   // Quantum register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff <= rrts_pkg::QUANT_RESET;
      end else if (csr_valid && csr_ready) begin
         quant_ff <= csr_quantum_ticks;
      end
   end

   rrts_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_task_id   (req_task_id),
      .req_parent_id (req_parent_id),
      .req_value     (req_value),
      .req_detail    (req_detail),
      .req_delay     (req_delay),
      .ev_valid      (ev_valid),
      .ev_word       (ev_word),
      .ev_pop        (ev_pop)
   );

   rrts_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .quantum          (quant_ff),
      .ev_valid         (ev_valid),
      .ev_word          (ev_word),
      .ev_pop           (ev_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_target_task  (rsp_target_task),
      .rsp_value_a      (rsp_value_a),
      .rsp_value_b      (rsp_value_b),
      .rsp_ok           (rsp_ok),
      .rsp_running_task (rsp_running_task),
      .rsp_users_active (rsp_users_active),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== src/rrts_checker.sv =====
// Port-level checks of the scheduler and their binding to the top level.
module rrts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [rrts_pkg::KIND_W-1:0]    req_kind,
   input logic [rrts_pkg::ID_W-1:0]      req_task_id,
   input logic [rrts_pkg::ID_W-1:0]      req_parent_id,
   input logic [rrts_pkg::DATA_W-1:0]    req_value,
   input logic [rrts_pkg::DATA_W-1:0]    req_detail,
   input logic [rrts_pkg::DATA_W-1:0]    req_delay,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [rrts_pkg::RKIND_W-1:0]   rsp_result_kind,
   input logic [rrts_pkg::ID_W-1:0]      rsp_target_task,
   input logic [rrts_pkg::DATA_W-1:0]    rsp_value_a,
   input logic [rrts_pkg::DATA_W-1:0]    rsp_value_b,
   input logic                           rsp_ok,
   input logic [rrts_pkg::ID_W-1:0]      rsp_running_task,
   input logic                           rsp_users_active,
   input logic                           rsp_last,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [rrts_pkg::QUANT_W-1:0]   csr_quantum_ticks
);

   // A stalled result word stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_a) &&
      $stable(rsp_result_kind) && $stable(rsp_target_task) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // Only the done word closes an event.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_result_kind == rrts_pkg::RK_DONE))
      else $error("last flag disagrees with result kind");

   // Deliveries always report success.
   a_delivery_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_ok)
      else $error("delivery word without ok");

   // With user scheduling off the idle slot runs.
   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_users_active |-> rsp_running_task == '0)
      else $error("user task running while scheduling is off");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);

// ===== tb/round_robin_task_scheduler_test.sv =====
// Self-checking testbench for the round-robin task scheduler: predicted result words vs. the block.
module round_robin_task_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;

   typedef struct {
      logic [rrts_pkg::KIND_W-1:0] kind;
      logic [rrts_pkg::ID_W-1:0]   tid;
      logic [rrts_pkg::ID_W-1:0]   pin;
      logic [rrts_pkg::DATA_W-1:0] value;
      logic [rrts_pkg::DATA_W-1:0] detail;
      logic [rrts_pkg::DATA_W-1:0] delay;
   } sched_event_type;

   typedef struct {
      logic [rrts_pkg::RKIND_W-1:0] rkind;
      logic [rrts_pkg::ID_W-1:0]    target;
      logic [rrts_pkg::DATA_W-1:0]  va;
      logic [rrts_pkg::DATA_W-1:0]  vb;
      logic                         ok;
      logic [rrts_pkg::ID_W-1:0]    running;
      logic                         users;
      logic                         last;
   } sched_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [rrts_pkg::KIND_W-1:0] req_kind = '0;
   logic [rrts_pkg::ID_W-1:0] req_task_id = '0, req_parent_id = '0;
   logic [rrts_pkg::DATA_W-1:0] req_value = '0, req_detail = '0, req_delay = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [rrts_pkg::RKIND_W-1:0] rsp_result_kind;
   logic [rrts_pkg::ID_W-1:0] rsp_target_task, rsp_running_task;
   logic [rrts_pkg::DATA_W-1:0] rsp_value_a, rsp_value_b;
   logic rsp_ok, rsp_users_active, rsp_last;
   logic csr_valid = 0;
   logic csr_ready;
   logic [rrts_pkg::QUANT_W-1:0] csr_quantum_ticks = '0;

   round_robin_task_scheduler #(.TASK_SLOTS(NSLOT)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_task_id(req_task_id), .req_parent_id(req_parent_id),
      .req_value(req_value), .req_detail(req_detail), .req_delay(req_delay),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_target_task(rsp_target_task),
      .rsp_value_a(rsp_value_a), .rsp_value_b(rsp_value_b), .rsp_ok(rsp_ok),
      .rsp_running_task(rsp_running_task), .rsp_users_active(rsp_users_active),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_quantum_ticks(csr_quantum_ticks)
   );

   // Shadow scheduler state.
   logic [rrts_pkg::ST_W-1:0]    sh_state  [NSLOT];
   logic [rrts_pkg::ID_W-1:0]    sh_parent [NSLOT];
   logic [rrts_pkg::ID_W-1:0]    sh_await  [NSLOT];
   logic [rrts_pkg::DATA_W-1:0]  sh_code   [NSLOT];
   logic [rrts_pkg::DATA_W-1:0]  sh_wake   [NSLOT];
   logic [rrts_pkg::DATA_W-1:0]  sh_tmo    [NSLOT];
   logic                         sh_timed  [NSLOT];
   logic [rrts_pkg::SLICE_W-1:0] sh_slice  [NSLOT];
   int unsigned                  sh_cur;
   logic                         sh_users;
   logic [rrts_pkg::DATA_W-1:0]  sh_ticks;
   logic [rrts_pkg::QUANT_W-1:0] sh_quant;

   sched_event_type pending_events[$];
   sched_word_type  expected_words[$];
   sched_word_type  event_words[$];
   int errors = 0;

   bit hold_off = 0;       // long receiver hold-off request
   int hold_cnt = 0;       // cycles held off so far
   bit sender_pause = 0;   // sender waits for drain

   initial forever #5 clock = ~clock;

   task automatic report(input string what, input logic [rrts_pkg::DATA_W-1:0] got,
                         input logic [rrts_pkg::DATA_W-1:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void push_word(input logic [rrts_pkg::RKIND_W-1:0] k,
                                     input int unsigned t,
                                     input logic [rrts_pkg::DATA_W-1:0] a,
                                     input logic [rrts_pkg::DATA_W-1:0] b,
                                     input logic ok, input logic last);
      sched_word_type w;
      if (event_words.size() >= rrts_pkg::MAX_RESULTS) return;
      w.rkind = k; w.target = t[3:0]; w.va = a; w.vb = b; w.ok = ok; w.last = last;
      w.running = '0; w.users = 0;
      event_words.push_back(w);
   endfunction

   function automatic void wipe_slot(input int unsigned s);
      sh_state[s] = rrts_pkg::SS_UNUSED; sh_parent[s] = '0; sh_await[s] = '0;
      sh_code[s] = '0; sh_wake[s] = '0; sh_tmo[s] = '0; sh_timed[s] = 0; sh_slice[s] = '0;
   endfunction

   function automatic int unsigned first_ready_after(input int unsigned after);
      int unsigned s;
      for (int unsigned n = 1; n < NSLOT; n++) begin
         s = 1 + ((after + n - 1) % (NSLOT - 1));
         if (sh_state[s] == rrts_pkg::SS_READY) return s;
      end
      return 0;
   endfunction

   function automatic void run_slot(input int unsigned s);
      sh_cur = s; sh_state[s] = rrts_pkg::SS_RUNNING; sh_slice[s] = '0;
   endfunction

   function automatic void to_idle();
      sh_users = 0; sh_cur = 0; sh_state[0] = rrts_pkg::SS_RUNNING;
   endfunction

   function automatic void pick_next();
      int unsigned c, n;
      c = sh_cur;
      if (sh_state[c] == rrts_pkg::SS_RUNNING) sh_state[c] = rrts_pkg::SS_READY;
      n = first_ready_after(c);
      if (n == 0) begin
         if (sh_state[c] == rrts_pkg::SS_READY) sh_state[c] = rrts_pkg::SS_RUNNING;
         else to_idle();
      end else run_slot(n);
   endfunction

   function automatic void free_slot(input int unsigned s);
      push_word(rrts_pkg::RK_RELEASE, s, sh_code[s], '0, 1, 0);
      wipe_slot(s);
   endfunction

   function automatic void notify_parent(input int unsigned ch);
      int unsigned p;
      p = sh_parent[ch];
      if (p == 0 || sh_state[p] != rrts_pkg::SS_BLOCKED ||
          (sh_await[p] != 0 && sh_await[p] != ch))
         return;
      push_word(rrts_pkg::RK_WAKE, p, rrts_pkg::DATA_W'(ch), sh_code[ch], 1, 0);
      sh_state[p] = rrts_pkg::SS_READY; sh_timed[p] = 0;
      free_slot(ch);
   endfunction

   function automatic bit can_reap(input int unsigned p, input int unsigned ch);
      return ch != 0 && sh_parent[ch] == p && sh_state[ch] == rrts_pkg::SS_EXITED;
   endfunction

   function automatic void reset_shadow();
      for (int s = 0; s < NSLOT; s++) wipe_slot(s);
      sh_state[0] = rrts_pkg::SS_RUNNING; sh_cur = 0; sh_users = 0; sh_ticks = '0;
      sh_quant = rrts_pkg::QUANT_RESET;
   endfunction

   // Predict all result words of one event and queue them.
   function automatic void predict_event(input sched_event_type e);
      int unsigned c, tid, pin, tgt, s;
      logic ok;
      logic [rrts_pkg::DATA_W-1:0] va, vb;
      bit uctx, found;
      c = sh_cur; tid = e.tid; pin = e.pin; tgt = 0; ok = 0; va = '0; vb = '0;
      uctx = sh_users && c != 0;
      event_words.delete();
      case (e.kind)
         rrts_pkg::EV_CREATE: begin
            found = 0;
            for (s = 1; s < NSLOT && !found; s++) begin
               if (sh_state[s] == rrts_pkg::SS_UNUSED) begin
                  wipe_slot(s);
                  sh_state[s] = rrts_pkg::SS_READY; sh_parent[s] = pin[3:0];
                  tgt = s; va = rrts_pkg::DATA_W'(s); ok = 1; found = 1;
               end
            end
         end
         rrts_pkg::EV_START: begin
            if (!sh_users) begin
               s = first_ready_after(0);
               if (s != 0) begin
                  sh_state[0] = rrts_pkg::SS_READY; sh_users = 1; run_slot(s);
                  tgt = s; ok = 1;
               end
            end
         end
         rrts_pkg::EV_TICK: begin
            sh_ticks++;
            for (s = 1; s < NSLOT; s++) begin
               if (sh_state[s] != rrts_pkg::SS_BLOCKED || !sh_timed[s] ||
                   sh_ticks < sh_wake[s]) continue;
               if (event_words.size() >= rrts_pkg::MAX_RESULTS - 1) break;
               push_word(rrts_pkg::RK_TIMEOUT, s, sh_tmo[s], '0, 1, 0);
               sh_timed[s] = 0; sh_state[s] = rrts_pkg::SS_READY;
            end
            ok = 1;
            if (sh_users && c != 0) begin
               if (sh_slice[c] < rrts_pkg::SLICE_MAX) sh_slice[c]++;
               if (sh_slice[c] >= sh_quant) pick_next();
            end
         end
         rrts_pkg::EV_YIELD: begin
            tgt = c;
            if (uctx) begin pick_next(); ok = 1; end
         end
         rrts_pkg::EV_EXIT: begin
            tgt = c;
            if (uctx) begin
               sh_code[c] = e.value; sh_state[c] = rrts_pkg::SS_EXITED;
               notify_parent(c);
               s = first_ready_after(c);
               if (s != 0) run_slot(s); else to_idle();
               ok = 1;
            end
         end
         rrts_pkg::EV_WAIT: begin
            tgt = tid;
            if (can_reap(c, tid)) begin
               va = rrts_pkg::DATA_W'(tid); vb = sh_code[tid]; ok = 1; free_slot(tid);
            end else if (c == 0 || sh_parent[tid] != c ||
                         sh_state[tid] == rrts_pkg::SS_UNUSED) begin
               va = '1;
            end else begin
               sh_state[c] = rrts_pkg::SS_BLOCKED; sh_await[c] = tid[3:0];
               pick_next(); ok = 1;
            end
         end
         rrts_pkg::EV_BLOCK: begin
            tgt = c;
            if (uctx) begin
               sh_state[c] = rrts_pkg::SS_BLOCKED;
               if (e.delay != 0) begin
                  sh_wake[c] = sh_ticks + e.delay; sh_tmo[c] = e.value; sh_timed[c] = 1;
               end else sh_timed[c] = 0;
               pick_next(); ok = 1;
            end
         end
         rrts_pkg::EV_WAKE: begin
            tgt = tid;
            if (tid != 0 && sh_state[tid] == rrts_pkg::SS_BLOCKED) begin
               push_word(rrts_pkg::RK_WAKE, tid, e.value, e.detail, 1, 0);
               sh_timed[tid] = 0; sh_state[tid] = rrts_pkg::SS_READY; ok = 1;
            end
         end
         rrts_pkg::EV_TERM: begin
            tgt = tid;
            if (tid != 0 && tid != c && sh_state[tid] != rrts_pkg::SS_UNUSED &&
                sh_state[tid] != rrts_pkg::SS_EXITED) begin
               sh_code[tid] = e.value; sh_state[tid] = rrts_pkg::SS_EXITED;
               notify_parent(tid); ok = 1;
            end
         end
         rrts_pkg::EV_REAP: begin
            tgt = tid;
            if (can_reap(pin, tid)) begin
               va = sh_code[tid]; ok = 1; free_slot(tid);
            end
         end
         default: ;
      endcase
      push_word(rrts_pkg::RK_DONE, tgt, va, vb, ok, 1);
      foreach (event_words[i]) begin
         event_words[i].running = sh_cur[3:0];
         event_words[i].users = sh_users;
         expected_words.push_back(event_words[i]);
      end
   endfunction

   function automatic sched_event_type make_event(input logic [rrts_pkg::KIND_W-1:0] k,
                                                  input int t, input int p,
                                                  input logic [rrts_pkg::DATA_W-1:0] v,
                                                  input logic [rrts_pkg::DATA_W-1:0] d,
                                                  input logic [rrts_pkg::DATA_W-1:0] dl);
      sched_event_type e;
      e.kind = k; e.tid = t[3:0]; e.pin = p[3:0]; e.value = v; e.detail = d; e.delay = dl;
      return e;
   endfunction

   function automatic logic [rrts_pkg::DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [rrts_pkg::DATA_W-1:0] rand_delay();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: return rand64();
         3: return '1;
         default: return rrts_pkg::DATA_W'($urandom_range(1, 12));
      endcase
   endfunction

   // Random event, weighted toward sequences that create, run and block tasks.
   function automatic sched_event_type random_event();
      int r;
      logic [rrts_pkg::KIND_W-1:0] k;
      r = $urandom_range(0, 99);
      if (r < 14) k = rrts_pkg::EV_CREATE;
      else if (r < 20) k = rrts_pkg::EV_START;
      else if (r < 42) k = rrts_pkg::EV_TICK;
      else if (r < 50) k = rrts_pkg::EV_YIELD;
      else if (r < 58) k = rrts_pkg::EV_EXIT;
      else if (r < 66) k = rrts_pkg::EV_WAIT;
      else if (r < 76) k = rrts_pkg::EV_BLOCK;
      else if (r < 84) k = rrts_pkg::EV_WAKE;
      else if (r < 90) k = rrts_pkg::EV_TERM;
      else if (r < 97) k = rrts_pkg::EV_REAP;
      else k = rrts_pkg::KIND_W'($urandom_range(10, 15));
      return make_event(k, (r % 5 == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6),
                        (r % 3 == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                        rand64(), rand64(), rand_delay());
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Driver: feeds pending events onto the request channel.
   // The word on the bus stays at the head of the queue until it is accepted.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && req_stall) begin
         // Hold the stalled word.
      end else begin
         if (req_valid) predict_event(pending_events.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (pending_events.size() > 0 && !sender_pause) begin
            sched_event_type e;
            e = pending_events[0];
            req_valid <= 1;
            req_kind <= e.kind; req_task_id <= e.tid; req_parent_id <= e.pin;
            req_value <= e.value; req_detail <= e.detail; req_delay <= e.delay;
            send_gap <= gap_len();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Receiver stall pattern, with a long hold-off on request counted here.
   int recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1;
         hold_cnt <= hold_cnt + 1;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
         if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
      end
   end

   // Monitor: compares each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report("unexpected result word", rsp_value_a, '0);
         end else begin
            sched_word_type w;
            w = expected_words.pop_front();
            if (rsp_result_kind !== w.rkind) report("result_kind", rsp_result_kind, w.rkind);
            if (rsp_target_task !== w.target) report("target_task", rsp_target_task, w.target);
            if (rsp_value_a !== w.va) report("value_a", rsp_value_a, w.va);
            if (rsp_value_b !== w.vb) report("value_b", rsp_value_b, w.vb);
            if (rsp_ok !== w.ok) report("ok", rsp_ok, w.ok);
            if (rsp_running_task !== w.running)
               report("running_task", rsp_running_task, w.running);
            if (rsp_users_active !== w.users) report("users_active", rsp_users_active, w.users);
            if (rsp_last !== w.last) report("last", rsp_last, w.last);
         end
      end
   end

   task automatic wait_drained();
      while (pending_events.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [rrts_pkg::QUANT_W-1:0] q);
      csr_valid <= 1;
      csr_quantum_ticks <= q;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      sh_quant = q;
   endtask

   initial begin
      reset_shadow();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: every kind, field extremes and the named corner cases.
      pending_events.push_back(make_event(rrts_pkg::EV_YIELD, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_START, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_WAIT, 1, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_CREATE, 0, 0, '1, '1, '1));
      pending_events.push_back(make_event(rrts_pkg::EV_CREATE, 15, 1, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_CREATE, 0, 1, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_START, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_START, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_WAIT, 2, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_BLOCK, 0, 0, 64'h55AA, '0, '1));
      pending_events.push_back(make_event(rrts_pkg::EV_BLOCK, 0, 0, 64'h1234, '0, 64'd2));
      pending_events.push_back(make_event(rrts_pkg::EV_TICK, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_TICK, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_WAKE, 1, 0, '1, '1, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_EXIT, 0, 0, '1, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_TERM, 3, 0, 64'hDEAD, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_TERM, 0, 0, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_REAP, 3, 1, '0, '0, '0));
      pending_events.push_back(make_event(rrts_pkg::EV_REAP, 2, 1, '0, '0, '0));
      pending_events.push_back(make_event(4'd15, 15, 15, '1, '1, '1));
      pending_events.push_back(make_event(4'd10, 0, 0, '0, '0, '0));
      for (int i = 0; i < 4; i++)
         pending_events.push_back(make_event(rrts_pkg::EV_TICK, 0, 0, '0, '0, '0));
      wait_drained();

      // Random phases across several quantum settings, the extremes among them.
      for (int ph = 0; ph < 5; ph++) begin
         logic [rrts_pkg::QUANT_W-1:0] q;
         q = (ph == 0) ? 8'd1 : (ph == 1) ? 8'd255 : (ph == 2) ? 8'd0 :
             rrts_pkg::QUANT_W'($urandom_range(2, 8));
         write_quantum(q);
         for (int i = 0; i < 52; i++) pending_events.push_back(random_event());
         if (ph == 1) begin
            // Long receiver hold-off while the sender keeps offering.
            hold_off = 1;
            while (hold_cnt < 400) @(posedge clock);
            hold_off = 0;
         end
         if (ph == 3) begin
            // Sender pauses mid-phase until everything has come back.
            while (pending_events.size() > 26) @(posedge clock);
            sender_pause = 1;
            while (req_valid || expected_words.size() != 0) @(posedge clock);
            sender_pause = 0;
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
